@@ rtl/triangle_tone_differential_pwm_macros.svh @@
// Assertion macros shared by the triangle tone PWM driver.
`ifndef TRIANGLE_TONE_DIFFERENTIAL_PWM_MACROS_SVH
`define TRIANGLE_TONE_DIFFERENTIAL_PWM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge out of reset.
`define TTDP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define TTDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TTDP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TTDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ttdp_pkg.sv @@
// Types and constants for the triangle tone PWM driver.
`default_nettype none

package ttdp_pkg;

    // Default parameter values
    localparam int RAMP_PEAK_DEF   = 31;
    localparam int SAMPLE_BITS_DEF = 10;

    // Field widths
    localparam int SIG_W    = 12;
    localparam int DUTY_W   = 10;
    localparam int PERIOD_W = 10;
    localparam int GAIN_W   = 8;
    localparam int TICK_W   = 8;
    localparam int READ_W   = 8;

    // Arithmetic constants
    localparam int PERIOD_FLOOR = 40;
    localparam int PERIOD_MAX   = 1023;
    localparam int PERIOD_RESET = 48;
    localparam int SIG_CLAMP    = 511;
    localparam int DUTY_MID     = 512;
    localparam int SIG_MAX      = 2047;
    localparam int SIG_MIN      = -2048;

    // Item kinds
    typedef enum logic [1:0] {
        FUNC_CONV = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_PWM  = 2'd2
    } ttdp_func_t;

    // Architectural state apart from the ramp position
    typedef struct packed {
        logic signed [SIG_W-1:0]  signal_level;
        logic                     ramp_rising;
        logic [GAIN_W-1:0]        latched_gain;
        logic [GAIN_W-1:0]        pending_gain;
        logic [PERIOD_W-1:0]      period;
        logic                     freq_channel;
        logic                     second_read;
        logic                     led;
        logic [DUTY_W-1:0]        duty_pos;
        logic [DUTY_W-1:0]        duty_neg;
    } ttdp_state_t;

    localparam ttdp_state_t STATE_RESET = '{
        signal_level: '0,
        ramp_rising:  1'b1,
        latched_gain: '0,
        pending_gain: GAIN_W'(1),
        period:       PERIOD_W'(PERIOD_RESET),
        freq_channel: 1'b0,
        second_read:  1'b0,
        led:          1'b0,
        duty_pos:     DUTY_W'(DUTY_MID),
        duty_neg:     DUTY_W'(DUTY_MID)
    };

endpackage

`default_nettype wire

@@ rtl/ttdp_if.sv @@
// Valid/ready channel interfaces for events in and results out.
`default_nettype none

interface ttdp_in_if
    import ttdp_pkg::*;
    #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF)
    ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output func, output adc_sample, input ready);
    modport sink   (input valid, input func, input adc_sample, output ready);
endinterface

interface ttdp_out_if
    import ttdp_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [DUTY_W-1:0]        duty_positive;
    logic [DUTY_W-1:0]        duty_negative;
    logic [TICK_W-1:0]        tick_interval;
    logic                     channel_select;
    logic                     led;
    logic signed [SIG_W-1:0]  signal_out;

    modport source (output valid, output duty_positive, output duty_negative,
                    output tick_interval, output channel_select, output led,
                    output signal_out, input ready);
    modport sink   (input valid, input duty_positive, input duty_negative,
                    input tick_interval, input channel_select, input led,
                    input signal_out, output ready);
endinterface

`default_nettype wire

@@ rtl/ttdp_step.sv @@
// Next-state logic for one item: conversion, generator tick or PWM tick.
`default_nettype none

module ttdp_step
    import ttdp_pkg::*;
#(
    parameter int RAMP_PEAK   = RAMP_PEAK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RAMP_W      = $clog2(RAMP_PEAK + 1) + 1
)
(
    input  wire logic                     mode,
    input  wire logic [1:0]               func,
    input  wire logic [SAMPLE_BITS-1:0]   adc_sample,
    input  wire ttdp_state_t              cur,
    input  wire logic signed [RAMP_W-1:0] ramp_cur,
    output ttdp_state_t                   upd,
    output logic signed [RAMP_W-1:0]      ramp_upd
);

    localparam int MAG_W  = RAMP_W - 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int WIDE_W = ((PROD_W > SIG_W) ? PROD_W : SIG_W) + 1;

    localparam logic signed [RAMP_W-1:0] PEAK_POS = RAMP_W'(RAMP_PEAK);
    localparam logic signed [RAMP_W-1:0] PEAK_NEG = -RAMP_W'(RAMP_PEAK);

    logic [SIG_W:0]              samp_ext;
    logic signed [SIG_W-1:0]     pass_level;
    logic [READ_W-1:0]           reading;
    logic [PERIOD_W:0]           p_sum;
    logic [PERIOD_W-1:0]         p_new;
    logic [GAIN_W-1:0]           gain;
    logic signed [RAMP_W-1:0]    step_n;
    logic [RAMP_W-1:0]           step_abs;
    logic [MAG_W-1:0]            mag;
    logic [PROD_W-1:0]           prod;
    logic [WIDE_W-1:0]           quot;
    logic signed [SIG_W-1:0]     ramp_level;
    logic                        reverse;
    logic signed [SIG_W-1:0]     clamped;
    logic signed [SIG_W-1:0]     pos_full;
    logic signed [SIG_W-1:0]     neg_full;

    // Passthrough sample, saturated to the signal range
    always_comb
    begin
        samp_ext = (SIG_W + 1)'(adc_sample);
        if (samp_ext > (SIG_W + 1)'(SIG_MAX))
            pass_level = SIG_W'(SIG_MAX);
        else
            pass_level = samp_ext[SIG_W-1:0];
    end

    // Control reading and smoothed period
    always_comb
    begin
        reading = adc_sample[SAMPLE_BITS-1 -: READ_W];
        p_sum   = {1'b0, cur.period} - (PERIOD_W + 1)'(cur.period[PERIOD_W-1:2])
                + (PERIOD_W + 1)'(reading);
        if (p_sum < (PERIOD_W + 1)'(PERIOD_FLOOR))
            p_new = PERIOD_W'(PERIOD_FLOOR);
        else if (p_sum > (PERIOD_W + 1)'(PERIOD_MAX))
            p_new = PERIOD_W'(PERIOD_MAX);
        else
            p_new = p_sum[PERIOD_W-1:0];
    end

    // Ramp step, gain latch at zero and scaled level
    always_comb
    begin
        gain     = (ramp_cur == '0) ? cur.pending_gain : cur.latched_gain;
        step_n   = cur.ramp_rising ? (ramp_cur + RAMP_W'(1)) : (ramp_cur - RAMP_W'(1));
        step_abs = step_n[RAMP_W-1] ? RAMP_W'(-step_n) : RAMP_W'(step_n);
        mag      = step_abs[MAG_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(gain);
        quot     = WIDE_W'(prod[PROD_W-1:2]);
        if (step_n[RAMP_W-1])
        begin
            if (quot > WIDE_W'(-SIG_MIN))
                ramp_level = SIG_W'(SIG_MIN);
            else
                ramp_level = -SIG_W'(quot);
        end
        else
        begin
            if (quot > WIDE_W'(SIG_MAX))
                ramp_level = SIG_W'(SIG_MAX);
            else
                ramp_level = SIG_W'(quot);
        end
        reverse = (step_n >= PEAK_POS) || (step_n <= PEAK_NEG);
    end

    // Signal clamp and complementary duties
    always_comb
    begin
        if (cur.signal_level > SIG_W'(SIG_CLAMP))
            clamped = SIG_W'(SIG_CLAMP);
        else if (cur.signal_level < -SIG_W'(SIG_CLAMP))
            clamped = -SIG_W'(SIG_CLAMP);
        else
            clamped = cur.signal_level;
        pos_full = SIG_W'(DUTY_MID) + clamped;
        neg_full = SIG_W'(DUTY_MID) - clamped;
    end

    // Select the update by item kind
    always_comb
    begin
        upd      = cur;
        ramp_upd = ramp_cur;
        case (func)
            FUNC_CONV:
            begin
                if (!mode)
                    upd.signal_level = pass_level;
                else if (!cur.second_read)
                    upd.second_read = 1'b1;
                else
                begin
                    upd.second_read  = 1'b0;
                    upd.freq_channel = ~cur.freq_channel;
                    if (cur.freq_channel)
                        upd.period = p_new;
                    else
                        upd.pending_gain = reading;
                end
            end
            FUNC_TICK:
            begin
                if (mode)
                begin
                    upd.latched_gain = gain;
                    upd.signal_level = ramp_level;
                    upd.ramp_rising  = reverse ? ~cur.ramp_rising : cur.ramp_rising;
                    ramp_upd         = step_n;
                end
            end
            FUNC_PWM:
            begin
                upd.led      = ~cur.led;
                upd.duty_pos = pos_full[DUTY_W-1:0];
                upd.duty_neg = neg_full[DUTY_W-1:0];
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/triangle_tone_differential_pwm.sv @@
// Path: an item accepted into the input register is stepped and shows its result on results from the result register.
// Throughput: one item per cycle while results is not stalled; input register, one pass of next-state logic,
// result register. A stalled result holds the pipe; one more item is still taken.
// Reset: asynchronous, active low; mode is passthrough, duties 512/512,
// period 48, ramp at zero and rising, pending gain 1.
`default_nettype none

`include "triangle_tone_differential_pwm_macros.svh"

module triangle_tone_differential_pwm
    import ttdp_pkg::*;
#(
    parameter int RAMP_PEAK   = RAMP_PEAK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    ttdp_in_if.sink           events,
    ttdp_out_if.source        results
);

    localparam int RAMP_W = $clog2(RAMP_PEAK + 1) + 1;

    logic                      mode_reg;
    logic                      s1_valid_reg, s1_valid_next;
    logic [1:0]                s1_func_reg;
    logic [SAMPLE_BITS-1:0]    s1_sample_reg;
    logic                      out_valid_reg, out_valid_next;
    ttdp_state_t               state_reg, state_next, upd;
    logic signed [RAMP_W-1:0]  ramp_reg, ramp_next, ramp_upd;
    logic                      advance, accept, fire;

    logic [DUTY_W-1:0]         duty_pos_reg, duty_neg_reg;
    logic [TICK_W-1:0]         tick_reg;
    logic                      chan_reg, led_reg;
    logic signed [SIG_W-1:0]   sig_reg;

    // Handshake control
    assign advance       = !out_valid_reg || results.ready;
    assign events.ready  = !s1_valid_reg || advance;
    assign accept        = events.valid && events.ready;
    assign fire          = s1_valid_reg && advance;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= events.func;
            s1_sample_reg <= events.adc_sample;
        end
    end

    // Next-state logic
    ttdp_step #(
        .RAMP_PEAK   (RAMP_PEAK),
        .SAMPLE_BITS (SAMPLE_BITS),
        .RAMP_W      (RAMP_W)
    ) u_step (
        .mode       (mode_reg),
        .func       (s1_func_reg),
        .adc_sample (s1_sample_reg),
        .cur        (state_reg),
        .ramp_cur   (ramp_reg),
        .upd        (upd),
        .ramp_upd   (ramp_upd)
    );

    assign state_next = fire ? upd : state_reg;
    assign ramp_next  = fire ? ramp_upd : ramp_reg;

    // State and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            ramp_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            ramp_reg      <= ramp_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            duty_pos_reg <= upd.duty_pos;
            duty_neg_reg <= upd.duty_neg;
            tick_reg     <= upd.period[PERIOD_W-1:2];
            chan_reg     <= upd.freq_channel;
            led_reg      <= upd.led;
            sig_reg      <= upd.signal_level;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.duty_positive  = duty_pos_reg;
    assign results.duty_negative  = duty_neg_reg;
    assign results.tick_interval  = tick_reg;
    assign results.channel_select = chan_reg;
    assign results.led            = led_reg;
    assign results.signal_out     = sig_reg;

    // Checks
    `TTDP_ASSERT_IMPLIES(a_duty_sum, clk, rst_n, results.valid, (11'(results.duty_positive) + 11'(results.duty_negative)) == 11'(2 * DUTY_MID))
    `TTDP_ASSERT_IMPLIES(a_ramp_bound, clk, rst_n, 1'b1, (ramp_reg <= RAMP_W'(RAMP_PEAK)) && (ramp_reg >= -RAMP_W'(RAMP_PEAK)))
    `TTDP_ASSERT_IMPLIES(a_period_floor, clk, rst_n, 1'b1, state_reg.period >= PERIOD_W'(PERIOD_FLOOR))
    `TTDP_ASSERT_NEXT(a_led_toggle, clk, rst_n, fire && (s1_func_reg == FUNC_PWM), state_reg.led != $past(state_reg.led))

endmodule

`default_nettype wire
